[sv/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the set-associative LRU cache lookup block.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 64;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 4;

    localparam int SETB_W  = 3;
    localparam int BLKB_W  = 6;
    localparam int WAYS_W  = 4;

    localparam logic [SETB_W-1:0] SETB_RST = '0;
    localparam logic [BLKB_W-1:0] BLKB_RST = '0;
    localparam logic [WAYS_W-1:0] WAYS_RST = 4'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic clr;     // clear one row of valid bits
        logic load;    // capture a new address
        logic split;   // form set and tag, read the set
        logic lookup;  // compare, pick way, write back, report
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
    } dp_stat_t;

endpackage

[sv/slc_ctrl.sv]
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: clearing pass after reset, then split and lookup per transaction.
// ----------------------------------------------------------------------------
module slc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output slc_pkg::dp_cmd_t  cmd,
    input  slc_pkg::dp_stat_t stat
);
    import slc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SPLIT = 4'b0100,
        S_LOOK  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == S_CLEAR) || (state_reg == S_SPLIT);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                // write-back lands before the next read, so a new item may follow
                cmd.lookup = 1'b1;
                state_next = accept ? S_SPLIT : S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/slc_dp.sv]
// ----------------------------------------------------------------------------
// slc_dp
// Datapath: address split, set storage, tag compare, LRU pick and counters.
// ----------------------------------------------------------------------------
module slc_dp
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  slc_pkg::dp_cmd_t              cmd,
    output slc_pkg::dp_stat_t             stat,
    input  logic [slc_pkg::ADDR_W-1:0]    address,
    input  logic [slc_pkg::SETB_W-1:0]    set_bits,
    input  logic [slc_pkg::BLKB_W-1:0]    block_bits,
    input  logic [slc_pkg::WAYS_W-1:0]    ways_in_use,
    output logic                          done,
    output logic [1:0]                    outcome,
    output logic [slc_pkg::CNT_W-1:0]     hit_total,
    output logic [slc_pkg::CNT_W-1:0]     miss_total,
    output logic [slc_pkg::CNT_W-1:0]     evict_total
);
    import slc_pkg::*;

    localparam int ROWS   = 1 << MAX_SET_BITS;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int LVLS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NP     = 1 << LVLS;
    localparam int WAY_W  = LVLS;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);

    logic [MAX_WAYS-1:0]              valid_mem [ROWS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_mem   [ROWS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_mem [ROWS];

    logic [ADDR_W-1:0]                addr_reg;
    logic [SET_W-1:0]                 set_reg;
    logic [TAG_W-1:0]                 tag_reg;
    logic [MAX_WAYS-1:0]              vrow_reg;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   trow_reg;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] srow_reg;
    logic [SET_W-1:0]                 clr_cnt_reg;
    logic [STAMP_W-1:0]               clock_reg;
    logic [CNT_W-1:0]                 hit_reg;
    logic [CNT_W-1:0]                 miss_reg;
    logic [CNT_W-1:0]                 evict_reg;
    logic                             done_reg;
    logic [1:0]                       outcome_reg;

    // address split
    logic [SETB_W-1:0]   s_eff;
    logic [6:0]          sb_sum;
    logic [ADDR_W-1:0]   set_wide;
    logic [SET_W-1:0]    set_c;
    logic [TAG_W-1:0]    tag_c;

    assign s_eff    = (int'(set_bits) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS) : set_bits;
    assign sb_sum   = 7'(s_eff) + 7'(block_bits);
    assign set_wide = (addr_reg >> block_bits) & ((ADDR_W'(1) << s_eff) - ADDR_W'(1));
    assign set_c    = set_wide[SET_W-1:0];
    assign tag_c    = (sb_sum >= 7'd64) ? '0 : (addr_reg >> sb_sum);

    // lookup
    logic [WCNT_W-1:0]       ways_eff;
    logic [MAX_WAYS-1:0]     act;
    logic [MAX_WAYS-1:0]     match;
    logic [MAX_WAYS-1:0]     empty;
    logic [WAY_W-1:0]        hit_idx;
    logic [WAY_W-1:0]        empty_idx;
    logic [WAY_W-1:0]        way_sel;
    logic                    hit;
    logic                    has_empty;
    logic [STAMP_W:0]        key  [2*NP-1];
    logic [WAY_W-1:0]        kidx [2*NP-1];
    logic [STAMP_W-1:0]      stamp_new;
    logic [MAX_WAYS-1:0]              vrow_new;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   trow_new;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] srow_new;

    always_comb
    begin
        if (ways_in_use == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (int'(ways_in_use) > MAX_WAYS)
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_in_use);
        end
    end

    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            act[w]   = (w < int'(ways_eff));
            match[w] = act[w] && vrow_reg[w] && (trow_reg[w] == tag_reg);
            empty[w] = act[w] && !vrow_reg[w];
            if (match[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (empty[w])
            begin
                empty_idx = WAY_W'(w);
            end
        end
        hit       = |match;
        has_empty = |empty;
    end

    // oldest-stamp tree; inactive ways lose, ties go to the lower way
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            key[NP-1+i]  = {1'b1, {STAMP_W{1'b0}}};
            kidx[NP-1+i] = WAY_W'(i);
            if (i < MAX_WAYS)
            begin
                if (act[i])
                begin
                    key[NP-1+i] = {1'b0, srow_reg[i]};
                end
            end
        end
        for (int n = NP - 2; n >= 0; n--)
        begin
            if (key[2*n+2] < key[2*n+1])
            begin
                key[n]  = key[2*n+2];
                kidx[n] = kidx[2*n+2];
            end
            else
            begin
                key[n]  = key[2*n+1];
                kidx[n] = kidx[2*n+1];
            end
        end
    end

    assign stamp_new = clock_reg + STAMP_W'(1);

    always_comb
    begin
        if (hit)
        begin
            way_sel = hit_idx;
        end
        else if (has_empty)
        begin
            way_sel = empty_idx;
        end
        else
        begin
            way_sel = kidx[0];
        end
        vrow_new = vrow_reg;
        trow_new = trow_reg;
        srow_new = srow_reg;
        vrow_new[way_sel] = 1'b1;
        trow_new[way_sel] = tag_reg;
        srow_new[way_sel] = stamp_new;
    end

    assign stat.clr_last = (clr_cnt_reg == SET_W'(ROWS - 1));

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            valid_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.lookup)
        begin
            valid_mem[set_reg] <= vrow_new;
            tag_mem[set_reg]   <= trow_new;
            stamp_mem[set_reg] <= srow_new;
        end
        if (cmd.split)
        begin
            vrow_reg <= valid_mem[set_c];
            trow_reg <= tag_mem[set_c];
            srow_reg <= stamp_mem[set_c];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= address;
        end
        if (cmd.split)
        begin
            set_reg <= set_c;
            tag_reg <= tag_c;
        end
        if (cmd.lookup)
        begin
            outcome_reg <= hit ? OUT_HIT : (has_empty ? OUT_FILL : OUT_EVICT);
        end
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            clock_reg   <= '0;
            hit_reg     <= '0;
            miss_reg    <= '0;
            evict_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.lookup;
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cmd.lookup)
            begin
                clock_reg <= stamp_new;
                if (hit)
                begin
                    if (hit_reg != CNT_MAX)
                    begin
                        hit_reg <= hit_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (miss_reg != CNT_MAX)
                    begin
                        miss_reg <= miss_reg + CNT_W'(1);
                    end
                    if (!has_empty && (evict_reg != CNT_MAX))
                    begin
                        evict_reg <= evict_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign done        = done_reg;
    assign outcome     = outcome_reg;
    assign hit_total   = hit_reg;
    assign miss_total  = miss_reg;
    assign evict_total = evict_reg;

endmodule

[sv/set_assoc_lru_cache_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative cache lookup with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
//   channel   handshake                       payload
//   input     start & !busy                   address
//   result    done (one-cycle strobe)         outcome, hit_total, miss_total,
//                                             evict_total
//   config    psel & penable & pwrite, APB    set_bits, block_bits, ways_in_use
//
// A transaction first splits the address and reads the set row from the set
// memories, then compares tags, picks the way, writes the row back and
// registers done. A new transaction is taken in the write-back cycle.
// After reset a clearing pass over all 2**MAX_SET_BITS rows resets the valid
// bits; busy is high during it. The receiver cannot stall: done is seen once.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [slc_pkg::ADDR_W-1:0]    address,
    output logic                          done,
    output logic [1:0]                    outcome,
    output logic [slc_pkg::CNT_W-1:0]     hit_total,
    output logic [slc_pkg::CNT_W-1:0]     miss_total,
    output logic [slc_pkg::CNT_W-1:0]     evict_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slc_pkg::PADDR_W-1:0]   paddr,
    input  logic [slc_pkg::DATA_W-1:0]    pwdata,
    output logic [slc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import slc_pkg::*;

    logic [SETB_W-1:0] set_bits_reg;
    logic [BLKB_W-1:0] block_bits_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic              wr_en;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SETB_RST;
            block_bits_reg <= BLKB_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SET_BITS:   set_bits_reg   <= pwdata[SETB_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[BLKB_W-1:0];
                REG_WAYS:       ways_reg       <= pwdata[WAYS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = DATA_W'(set_bits_reg);
            REG_BLOCK_BITS: prdata = DATA_W'(block_bits_reg);
            REG_WAYS:       prdata = DATA_W'(ways_reg);
            default:        prdata = '0;
        endcase
    end

    slc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    slc_dp
    #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .address     (address),
        .set_bits    (set_bits_reg),
        .block_bits  (block_bits_reg),
        .ways_in_use (ways_reg),
        .done        (done),
        .outcome     (outcome),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total)
    );

endmodule
